// ===== rtl/core/sacfl_pkg.sv =====
// shared constants and types of the set-associative cache lookup core
// no dependencies, compiled first
`default_nettype none

package sacfl_pkg;

    // default geometry
    localparam int LINE_BYTES_DEF = 16;
    localparam int NUM_SETS_DEF   = 16;
    localparam int NUM_WAYS_DEF   = 4;

    // configuration port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // register index, taken from paddr[2]
    typedef enum logic [0:0] {
        CFG_DCACHE_MODE = 1'b0,
        CFG_UNUSED      = 1'b1
    } t_cfg_reg;

    // access attributes handed to the way compare
    typedef struct packed {
        logic is_write;
        logic dcache_mode;
    } t_access_ctl;

endpackage

`default_nettype wire

// ===== rtl/core/sacfl_req_if.sv =====
// request channel of the cache lookup core: valid/ready plus access fields
// standalone, no package needed
`default_nettype none

interface sacfl_req_if;
    logic        valid;
    logic        ready;
    logic [31:0] address;
    logic        is_write;

    modport source (output valid, output address, output is_write, input ready);
    modport sink   (input valid, input address, input is_write, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/sacfl_rsp_if.sv =====
// response channel of the cache lookup core: valid/ready plus hit and counters
// standalone, no package needed
`default_nettype none

interface sacfl_rsp_if;
    logic        valid;
    logic        ready;
    logic        hit;
    logic [31:0] hit_total;
    logic [31:0] miss_total;
    logic [31:0] access_total;

    modport source (
        output valid, output hit, output hit_total, output miss_total,
        output access_total, input ready
    );
    modport sink (
        input valid, input hit, input hit_total, input miss_total,
        input access_total, output ready
    );
endinterface

`default_nettype wire

// ===== rtl/core/sacfl_row_ram.sv =====
// one-write one-read memory holding a full set row, registered read data
// generic, no package needed
`default_nettype none

module sacfl_row_ram #(
    parameter int DEPTH  = 16,
    parameter int DATA_W = 8,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [DATA_W-1:0] i_wdata,
    input  wire logic              i_re,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== rtl/core/sacfl_way_match.sv =====
// parallel tag compare of one set, fifo victim choice and next row contents
// depends on sacfl_pkg
`default_nettype none

module sacfl_way_match #(
    parameter int NUM_WAYS = 4,
    parameter int TAG_W    = 24,
    parameter int WAY_W    = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1
) (
    input  wire logic [NUM_WAYS-1:0][TAG_W-1:0] i_tags,
    input  wire logic [NUM_WAYS-1:0]            i_valid,
    input  wire logic [WAY_W-1:0]               i_ptr,
    input  wire logic [TAG_W-1:0]               i_tag,
    input  wire sacfl_pkg::t_access_ctl          i_ctl,
    output logic                                o_hit,
    output logic      [NUM_WAYS-1:0][TAG_W-1:0] o_tags,
    output logic      [NUM_WAYS-1:0]            o_valid,
    output logic      [WAY_W-1:0]               o_ptr
);

    import sacfl_pkg::*;

    logic                invalidate;
    logic [NUM_WAYS-1:0] match;
    logic [NUM_WAYS-1:0] valid_kept;

    assign invalidate = i_ctl.is_write & i_ctl.dcache_mode;

    always_comb begin
        for (int w = 0; w < NUM_WAYS; w++) begin
            match[w]      = (i_tags[w] == i_tag);
            // a dcache write drops every way holding this tag
            valid_kept[w] = i_valid[w] & ~(invalidate & match[w]);
        end
    end

    assign o_hit = |(valid_kept & match);

    always_comb begin
        o_tags  = i_tags;
        o_valid = valid_kept;
        o_ptr   = i_ptr;
        if (!o_hit) begin
            for (int w = 0; w < NUM_WAYS; w++) begin
                if (WAY_W'(w) == i_ptr) begin
                    o_tags[w]  = i_tag;
                    o_valid[w] = 1'b1;
                end
            end
            if (i_ptr == WAY_W'(NUM_WAYS - 1)) begin
                o_ptr = '0;
            end else begin
                o_ptr = i_ptr + 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/set_assoc_cache_fifo_lookup_core.sv =====
// Set-associative cache hit/miss engine with fifo replacement. Each request
// transaction carries a byte address and a write flag; each one gives exactly
// one response transaction with the hit flag and the hit, miss and access
// totals counted up to and including it (32 bits, wrapping). Set and tag are
// address / LINE_BYTES modulo and divided by NUM_SETS. One transaction is
// taken every cycle unless back-pressure or the clearing pass stalls: the set
// row (tags, valid bits, fifo pointer) is read from a row memory at the accept
// edge, compared in stage one and rewritten when stage one advances into the
// response register, and a row just rewritten is forwarded to a following
// access of the same set, so back-to-back accesses to one set still go at
// full rate. After reset a clearing pass over all NUM_SETS rows zeroes the
// row memory; requests are held off meanwhile, configuration writes are taken
// at once. Register dcache_mode (byte address 0, bit 0) selects data-cache
// behaviour, where a write drops matching ways and so always refills as a miss.
// depends on sacfl_pkg, sacfl_req_if, sacfl_rsp_if, sacfl_row_ram, sacfl_way_match
`default_nettype none

module set_assoc_cache_fifo_lookup_core #(
    parameter int LINE_BYTES = sacfl_pkg::LINE_BYTES_DEF,
    parameter int NUM_SETS   = sacfl_pkg::NUM_SETS_DEF,
    parameter int NUM_WAYS   = sacfl_pkg::NUM_WAYS_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    sacfl_req_if.sink                             i_req,
    sacfl_rsp_if.source                           o_rsp,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [sacfl_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [sacfl_pkg::APB_DATA_W-1:0] pwdata,
    output logic      [sacfl_pkg::APB_DATA_W-1:0] prdata,
    output logic                                  pready
);

    import sacfl_pkg::*;

    // geometry derived from the parameters
    localparam longint unsigned TAG_MAX =
        64'hFFFF_FFFF / (LINE_BYTES * NUM_SETS);
    localparam int TAG_W  = (TAG_MAX == 0) ? 1 : $clog2(TAG_MAX + 1);
    localparam int SET_W  = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
    localparam int WAY_W  = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
    localparam int ROW_W  = NUM_WAYS * TAG_W + NUM_WAYS + WAY_W;

    // ---------------------------------------------------------------
    // configuration port
    // ---------------------------------------------------------------
    logic     r_dcache_mode;
    t_cfg_reg cfg_sel;
    logic     cfg_wr;

    assign cfg_sel = t_cfg_reg'(paddr[2]);
    assign cfg_wr  = psel & penable & pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dcache_mode <= 1'b0;
        end else if (cfg_wr && cfg_sel == CFG_DCACHE_MODE) begin
            r_dcache_mode <= pwdata[0];
        end
    end

    always_comb begin
        prdata = '0;
        case (cfg_sel)
            CFG_DCACHE_MODE: prdata[0] = r_dcache_mode;
            default:         prdata    = '0;
        endcase
    end

    // ---------------------------------------------------------------
    // address split
    // ---------------------------------------------------------------
    logic [31:0]      line_idx;
    logic [SET_W-1:0] in_set;
    logic [TAG_W-1:0] in_tag;

    assign line_idx = i_req.address / 32'(LINE_BYTES);
    assign in_set   = SET_W'(line_idx % 32'(NUM_SETS));
    assign in_tag   = TAG_W'(line_idx / 32'(NUM_SETS));

    // ---------------------------------------------------------------
    // handshake and pipeline control
    // ---------------------------------------------------------------
    logic             r_clr_busy;
    logic [SET_W-1:0] r_clr_idx;
    logic             r_s1_vld;
    logic [SET_W-1:0] r_s1_set;
    logic [TAG_W-1:0] r_s1_tag;
    logic             r_s1_wr;
    logic             r_out_vld;
    logic             r_out_hit;
    logic [31:0]      r_hit_cnt;
    logic [31:0]      r_miss_cnt;
    logic [31:0]      r_acc_cnt;
    logic             r_fwd_sel;
    logic [ROW_W-1:0] r_fwd_row;

    logic             out_take;
    logic             s1_adv;
    logic             in_ready;
    logic             in_acc;

    assign out_take = r_out_vld & o_rsp.ready;
    assign s1_adv   = r_s1_vld & (~r_out_vld | out_take);
    assign in_ready = ~r_clr_busy & (~r_s1_vld | s1_adv);
    assign in_acc   = i_req.valid & in_ready;

    assign i_req.ready = in_ready;

    // clearing pass over the row memory after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_idx  <= '0;
        end else if (r_clr_busy) begin
            if (r_clr_idx == SET_W'(NUM_SETS - 1)) begin
                r_clr_busy <= 1'b0;
            end
            r_clr_idx <= r_clr_idx + 1'b1;
        end
    end

    // ---------------------------------------------------------------
    // row memory and forwarding of a row written at the read edge
    // ---------------------------------------------------------------
    logic [ROW_W-1:0] ram_rdata;
    logic [ROW_W-1:0] cur_row;
    logic [ROW_W-1:0] new_row;
    logic             ram_we;
    logic [SET_W-1:0] ram_waddr;
    logic [ROW_W-1:0] ram_wdata;

    assign ram_we    = r_clr_busy | s1_adv;
    assign ram_waddr = r_clr_busy ? r_clr_idx : r_s1_set;
    assign ram_wdata = r_clr_busy ? '0 : new_row;

    sacfl_row_ram #(
        .DEPTH  (NUM_SETS),
        .DATA_W (ROW_W),
        .ADDR_W (SET_W)
    ) u_row_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (in_acc),
        .i_raddr (in_set),
        .o_rdata (ram_rdata)
    );

    assign cur_row = r_fwd_sel ? r_fwd_row : ram_rdata;

    // ---------------------------------------------------------------
    // compare and update of the set held in stage one
    // ---------------------------------------------------------------
    logic [NUM_WAYS-1:0][TAG_W-1:0] cur_tags;
    logic [NUM_WAYS-1:0]            cur_valid;
    logic [WAY_W-1:0]               cur_ptr;
    logic [NUM_WAYS-1:0][TAG_W-1:0] upd_tags;
    logic [NUM_WAYS-1:0]            upd_valid;
    logic [WAY_W-1:0]               upd_ptr;
    logic                           lookup_hit;
    t_access_ctl                    acc_ctl;

    // row layout: fifo pointer, valid bits, tags
    assign {cur_ptr, cur_valid, cur_tags} = cur_row;
    assign new_row = {upd_ptr, upd_valid, upd_tags};

    assign acc_ctl.is_write    = r_s1_wr;
    assign acc_ctl.dcache_mode = r_dcache_mode;

    sacfl_way_match #(
        .NUM_WAYS (NUM_WAYS),
        .TAG_W    (TAG_W),
        .WAY_W    (WAY_W)
    ) u_way_match (
        .i_tags  (cur_tags),
        .i_valid (cur_valid),
        .i_ptr   (cur_ptr),
        .i_tag   (r_s1_tag),
        .i_ctl   (acc_ctl),
        .o_hit   (lookup_hit),
        .o_tags  (upd_tags),
        .o_valid (upd_valid),
        .o_ptr   (upd_ptr)
    );

    // ---------------------------------------------------------------
    // stage one: accepted transaction waiting for its row
    // ---------------------------------------------------------------
    logic n_s1_vld;

    always_comb begin
        n_s1_vld = r_s1_vld;
        if (in_acc) begin
            n_s1_vld = 1'b1;
        end else if (s1_adv) begin
            n_s1_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_fwd_sel <= 1'b0;
        end else begin
            r_s1_vld <= n_s1_vld;
            if (in_acc) begin
                // the row being written at this edge is newer than the read
                r_fwd_sel <= s1_adv & (r_s1_set == in_set);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_set  <= in_set;
            r_s1_tag  <= in_tag;
            r_s1_wr   <= i_req.is_write;
            r_fwd_row <= new_row;
        end
    end

    // ---------------------------------------------------------------
    // result register and counters
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_hit_cnt  <= '0;
            r_miss_cnt <= '0;
            r_acc_cnt  <= '0;
        end else begin
            if (s1_adv) begin
                r_out_vld <= 1'b1;
                r_acc_cnt <= r_acc_cnt + 32'd1;
                if (lookup_hit) begin
                    r_hit_cnt <= r_hit_cnt + 32'd1;
                end else begin
                    r_miss_cnt <= r_miss_cnt + 32'd1;
                end
            end else if (out_take) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_hit <= lookup_hit;
        end
    end

    assign o_rsp.valid        = r_out_vld;
    assign o_rsp.hit          = r_out_hit;
    assign o_rsp.hit_total    = r_hit_cnt;
    assign o_rsp.miss_total   = r_miss_cnt;
    assign o_rsp.access_total = r_acc_cnt;

endmodule

`default_nettype wire

// ===== dv/set_assoc_cache_fifo_lookup_core_test.sv =====
`timescale 1ns / 100ps
// self-checking testbench of the set-associative cache lookup core (fifo replacement)
// depends on sacfl_pkg, sacfl_req_if, sacfl_rsp_if and the core with its submodules

module set_assoc_cache_fifo_lookup_core_test;
    import sacfl_pkg::*;

    localparam int LINE_BYTES = LINE_BYTES_DEF;
    localparam int NUM_SETS   = NUM_SETS_DEF;
    localparam int NUM_WAYS   = NUM_WAYS_DEF;

    // cycles with no transaction on either channel before the run is given up
    localparam int WATCHDOG_LIMIT = 3000;
    // the response is registered behind stage one, so this drain covers any tail
    localparam int DRAIN_CYCLES   = 6;
    // receiver hold-off that fills the core and backs up the request side
    localparam int LONG_HOLD_OFF  = 300;
    localparam int MAX_REPORTS    = 10;

    typedef struct {
        logic [31:0] address;
        logic        is_write;
    } t_access;

    typedef struct {
        logic        hit;
        logic [31:0] hit_total;
        logic [31:0] miss_total;
        logic [31:0] access_total;
    } t_lookup_result;

    logic i_clk;
    logic i_rst_n;

    // configuration port
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    sacfl_req_if req_ch ();
    sacfl_rsp_if rsp_ch ();

    set_assoc_cache_fifo_lookup_core #(
        .LINE_BYTES (LINE_BYTES),
        .NUM_SETS   (NUM_SETS),
        .NUM_WAYS   (NUM_WAYS)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // 20 ns clock
    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    // ------------------------------------------------------------------
    // cache model: own copy of tags, valid marks, fifo pointers, totals
    // ------------------------------------------------------------------
    logic [31:0] model_tag   [NUM_SETS][NUM_WAYS];
    logic        model_valid [NUM_SETS][NUM_WAYS];
    int unsigned cache_fifo  [NUM_SETS];
    logic [31:0] total_hits;
    logic [31:0] total_misses;
    logic [31:0] total_accesses;
    logic        dcache_on;

    t_access        pending_accesses [$];
    t_lookup_result expected_lookups [$];

    int  mismatch_count;
    int  gap_left;
    int  burst_left;
    int  idle_cycles;
    int  hold_off_left;
    int  stall_pct;
    int  stall_epoch;
    bit  long_hold_off_req;

    // one lookup: invalidate on a data-cache write, compare all ways, refill on a miss
    function automatic t_lookup_result predict_lookup(input logic [31:0] address,
                                                      input logic is_write);
        logic [31:0]    line_no;
        int unsigned    set_no;
        logic [31:0]    tag_val;
        int unsigned    victim;
        bit             found;
        t_lookup_result res;
        line_no = address / LINE_BYTES;
        set_no  = line_no % NUM_SETS;
        tag_val = line_no / NUM_SETS;
        found   = 1'b0;
        total_accesses = total_accesses + 32'd1;
        // data cache write: any way holding the tag is dropped, valid or not
        if (is_write && dcache_on) begin
            for (int w = 0; w < NUM_WAYS; w++) begin
                if (model_tag[set_no][w] == tag_val)
                    model_valid[set_no][w] = 1'b0;
            end
        end
        for (int w = 0; w < NUM_WAYS; w++) begin
            if (model_valid[set_no][w] && model_tag[set_no][w] == tag_val)
                found = 1'b1;
        end
        if (found) begin
            total_hits = total_hits + 32'd1;
        end else begin
            total_misses = total_misses + 32'd1;
            victim = cache_fifo[set_no] % NUM_WAYS;
            model_tag[set_no][victim]   = tag_val;
            model_valid[set_no][victim] = 1'b1;
            cache_fifo[set_no]          = (victim + 1) % NUM_WAYS;
        end
        res.hit          = found;
        res.hit_total    = total_hits;
        res.miss_total   = total_misses;
        res.access_total = total_accesses;
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("mismatch at %0t: %s", $time, msg);
    endtask

    task automatic check_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
            report_mismatch($sformatf("%s expected %h got %h", field, want, got));
    endtask

    // ------------------------------------------------------------------
    // request driver: bursts of random length, random gaps between them
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : access_driver
        bit offer;
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
        end else begin
            if (req_ch.valid && req_ch.ready) begin
                // predict from what was actually on the bus at the accept edge
                expected_lookups.push_back(predict_lookup(req_ch.address, req_ch.is_write));
                void'(pending_accesses.pop_front());
                if (burst_left > 0)
                    burst_left--;
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 40);
                    case ($urandom_range(0, 7))
                        0, 1:    gap_left = 0;
                        7:       gap_left = $urandom_range(10, 30);
                        default: gap_left = $urandom_range(1, 6);
                    endcase
                end
            end else if (!req_ch.valid && gap_left > 0) begin
                gap_left--;
            end
            offer = (gap_left == 0) && (pending_accesses.size() > 0);
            // valid is held while a transaction waits: offer stays set until the accept
            req_ch.valid <= offer;
            if (offer) begin
                req_ch.address  <= pending_accesses[0].address;
                req_ch.is_write <= pending_accesses[0].is_write;
            end
        end
    end

    // ------------------------------------------------------------------
    // response monitor and receiver stall pattern
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : result_monitor
        t_lookup_result want;
        bit             take;
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
        end else begin
            if (rsp_ch.valid && rsp_ch.ready) begin
                if (expected_lookups.size() == 0) begin
                    report_mismatch($sformatf("response with nothing expected, access_total %h",
                                              rsp_ch.access_total));
                end else begin
                    want = expected_lookups.pop_front();
                    check_field("hit", {31'd0, want.hit}, {31'd0, rsp_ch.hit});
                    check_field("hit_total", want.hit_total, rsp_ch.hit_total);
                    check_field("miss_total", want.miss_total, rsp_ch.miss_total);
                    check_field("access_total", want.access_total, rsp_ch.access_total);
                end
            end
            if (long_hold_off_req) begin
                long_hold_off_req = 1'b0;
                hold_off_left = LONG_HOLD_OFF;
            end
            if (hold_off_left > 0) begin
                hold_off_left--;
                take = 1'b0;
            end else begin
                // stall density is redrawn at the end of each epoch, none at all now and then
                stall_epoch++;
                if (stall_epoch >= 40) begin
                    stall_epoch = 0;
                    case ($urandom_range(0, 4))
                        0:       stall_pct = 0;
                        1:       stall_pct = 10;
                        2:       stall_pct = 30;
                        3:       stall_pct = 60;
                        default: stall_pct = 85;
                    endcase
                end
                take = ($urandom_range(0, 99) >= stall_pct);
            end
            rsp_ch.ready <= take;
        end
    end

    // watchdog on transactions of either channel
    always @(posedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    task automatic push_access(input logic [31:0] address, input logic is_write);
        t_access a;
        a.address  = address;
        a.is_write = is_write;
        pending_accesses.push_back(a);
    endtask

    // sender holds back until every expected response is in, then the tail settles
    task automatic wait_for_drain();
        while (pending_accesses.size() != 0 || expected_lookups.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // setup cycle then access cycle, register taken at the access edge
    task automatic write_register(input t_cfg_reg which, input logic [31:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {which, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (which == CFG_DCACHE_MODE)
            dcache_on = value[0];
    endtask

    // mostly a small tag pool per phase so sets fill, hit and evict; the rest fully random
    task automatic queue_random_phase(input int count, input int write_pct);
        logic [31:0] tag_pool [6];
        logic [31:0] tag_val;
        int unsigned set_no;
        int unsigned offset;
        logic [31:0] address;
        tag_pool[0] = 32'd0;
        tag_pool[1] = 32'h00FF_FFFF;
        for (int i = 2; i < 6; i++)
            tag_pool[i] = $urandom_range(0, 32'h00FF_FFFF);
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 99) < 75) begin
                tag_val = tag_pool[$urandom_range(0, 5)];
                set_no  = $urandom_range(0, NUM_SETS - 1);
                offset  = $urandom_range(0, LINE_BYTES - 1);
                address = (tag_val * NUM_SETS + set_no) * LINE_BYTES + offset;
            end else begin
                address = $urandom;
            end
            push_access(address, $urandom_range(0, 99) < write_pct);
        end
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin
        i_rst_n         = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        req_ch.valid    = 1'b0;
        req_ch.address  = '0;
        req_ch.is_write = 1'b0;
        rsp_ch.ready    = 1'b0;
        mismatch_count  = 0;
        gap_left        = 0;
        burst_left      = 8;
        idle_cycles     = 0;
        hold_off_left   = 0;
        stall_pct       = 0;
        stall_epoch     = 0;
        long_hold_off_req = 1'b0;
        for (int s = 0; s < NUM_SETS; s++) begin
            cache_fifo[s] = 0;
            for (int w = 0; w < NUM_WAYS; w++) begin
                model_tag[s][w]   = '0;
                model_valid[s][w] = 1'b0;
            end
        end
        total_hits     = '0;
        total_misses   = '0;
        total_accesses = '0;
        dcache_on      = 1'b0;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // instruction cache; upper bits of the write data must be ignored
        write_register(CFG_DCACHE_MODE, 32'hFFFF_FFFE);
        push_access(32'h0000_0000, 1'b0);   // cold miss
        push_access(32'h0000_0000, 1'b0);   // hit
        push_access(32'h0000_000F, 1'b0);   // same line, top offset
        push_access(32'hFFFF_FFFF, 1'b0);   // top set, top tag
        push_access(32'hFFFF_FFF0, 1'b1);   // write acts as a read here
        push_access(32'h0000_0100, 1'b0);   // fill the rest of set zero
        push_access(32'h0000_0200, 1'b1);
        push_access(32'h0000_0300, 1'b0);
        push_access(32'h0000_0400, 1'b0);   // evicts the first way
        push_access(32'h0000_0000, 1'b0);   // evicted line misses again
        push_access(32'h0000_0010, 1'b1);
        push_access(32'hAAAA_AAAA, 1'b1);
        push_access(32'h5555_5555, 1'b0);
        push_access(32'hAAAA_AAAA, 1'b0);
        wait_for_drain();

        // data cache; the spare register index must leave the mode alone
        write_register(CFG_DCACHE_MODE, 32'hFFFF_FFFF);
        write_register(CFG_UNUSED, 32'h0000_0000);
        push_access(32'h5555_5555, 1'b1);   // resident line dropped, refilled as a miss
        push_access(32'h5555_5555, 1'b0);   // hit
        push_access(32'h5555_5555, 1'b1);   // misses again
        push_access(32'h0000_0050, 1'b1);   // set five: tag zero matches a never-filled, invalid way
        push_access(32'h0000_0050, 1'b0);
        push_access(32'hFFFF_FFFF, 1'b1);
        push_access(32'hFFFF_FFFF, 1'b0);
        push_access(32'h0000_0100, 1'b1);
        push_access(32'h0000_0100, 1'b0);
        wait_for_drain();

        // random phases, alternating mode, one with a long receiver hold-off
        for (int ph = 0; ph < 6; ph++) begin
            write_register(CFG_DCACHE_MODE,
                           {31'($urandom_range(0, 32'h7FFF_FFFF)), ph[0]});
            if (ph == 2)
                long_hold_off_req = 1'b1;
            queue_random_phase(180, (ph % 3 == 0) ? 50 : 25);
            wait_for_drain();
        end

        if (mismatch_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
